>>> hw/rtl/csvt_pkg.sv
// Shared constants, types and a helper function of the CSV line field tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

    // Whitespace hold buffer depth (legal range 1 to 62).
    localparam int HOLD_DEPTH = 16;
    localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Which result the output register takes in a given cycle.
    typedef enum logic [2:0] {
        SEL_NONE  = 3'd0,
        SEL_FAST  = 3'd1,
        SEL_FLUSH = 3'd2,
        SEL_BYTE  = 3'd3,
        SEL_ENDB  = 3'd4
    } sel_t;

    typedef struct packed {
        logic accept;
        sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic has_flush;
        logic rest_endb;
        logic flush_done;
        logic plan_endb;
    } stat_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

>>> hw/rtl/csvt_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps

module csvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/csvt_ctrl.sv
// Controller state machine that sequences the results of each input byte.
`timescale 1ns / 1ps

module csvt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  csvt_pkg::stat_t stat,
    output csvt_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FLUSH = 4'b0010,
        ST_BYTE  = 4'b0100,
        ST_ENDB  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   ready;

    assign ready    = (state_reg == ST_IDLE) && stat.out_free;
    assign s_tready = ready;

    always_comb begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.sel    = csvt_pkg::SEL_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready) begin
                    cmd.accept = 1'b1;
                    cmd.sel    = csvt_pkg::SEL_FAST;
                    if (stat.has_flush) begin
                        state_next = ST_FLUSH;
                    end else if (stat.rest_endb) begin
                        state_next = ST_ENDB;
                    end
                end
            end
            ST_FLUSH: begin
                if (stat.out_free) begin
                    cmd.sel = csvt_pkg::SEL_FLUSH;
                    if (stat.flush_done) begin
                        state_next = ST_BYTE;
                    end
                end
            end
            ST_BYTE: begin
                if (stat.out_free) begin
                    cmd.sel    = csvt_pkg::SEL_BYTE;
                    state_next = stat.plan_endb ? ST_ENDB : ST_IDLE;
                end
            end
            ST_ENDB: begin
                if (stat.out_free) begin
                    cmd.sel    = csvt_pkg::SEL_ENDB;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/csvt_dp.sv
// Datapath: byte decode, line and quote state, hold buffer and output register.
`timescale 1ns / 1ps

module csvt_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      s_tdata,
    input  logic            s_tlast,
    output logic [7:0]      m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  csvt_pkg::cmd_t  cmd,
    output csvt_pkg::stat_t stat
);

    localparam int AW = csvt_pkg::HOLD_AW;
    localparam int CW = csvt_pkg::HOLD_CW;

    // Line and field state.
    logic          quoting_reg, quoting_next;
    logic          qwait_reg, qwait_next;
    logic          line_bytes_reg, line_bytes_next;
    logic          content_reg, content_next;
    logic [CW-1:0] held_reg, held_next;
    logic          ovf_reg, ovf_next;

    // Work left over from the accepted byte.
    logic [7:0]    byte_reg;
    logic          plan_endb_reg;
    logic          plan_ofb_reg;
    logic [CW-1:0] flush_len_reg;
    logic [CW-1:0] flush_idx_reg, flush_idx_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg, out_le_reg, out_te_reg, out_of_reg;
    logic [7:0]    out_ch_reg;

    // Decode of the byte on the input.
    logic          is_nl, content_en, ws_we, has_byte, end_a, le_a, of_a;
    logic          end_b, of_b, do_flush;
    logic          fast_valid, fast_kind, fast_le, fast_te, fast_of;
    logic [7:0]    fast_ch;
    logic [7:0]    rd_data;
    logic          load;

    always_comb begin
        quoting_next    = quoting_reg;
        qwait_next      = qwait_reg;
        line_bytes_next = line_bytes_reg;
        content_next    = content_reg;
        held_next       = held_reg;
        ovf_next        = ovf_reg;
        content_en      = 1'b0;
        ws_we           = 1'b0;
        has_byte        = 1'b0;
        end_a           = 1'b0;
        le_a            = 1'b0;
        of_a            = 1'b0;
        end_b           = 1'b0;
        of_b            = 1'b0;
        do_flush        = 1'b0;
        is_nl           = (s_tdata == csvt_pkg::CH_CR) || (s_tdata == csvt_pkg::CH_LF);

        if (is_nl) begin
            end_a           = line_bytes_reg;
            le_a            = 1'b1;
            of_a            = ovf_reg;
            line_bytes_next = 1'b0;
            quoting_next    = 1'b0;
            qwait_next      = 1'b0;
            content_next    = 1'b0;
            held_next       = '0;
            ovf_next        = 1'b0;
        end else begin
            line_bytes_next = 1'b1;
            if (qwait_reg && (s_tdata == csvt_pkg::CH_QUOTE)) begin
                // Doubled quote inside quotes: one literal quote byte.
                qwait_next = 1'b0;
                content_en = 1'b1;
            end else begin
                if (qwait_reg) begin
                    qwait_next   = 1'b0;
                    quoting_next = 1'b0;
                end
                if (s_tdata == csvt_pkg::CH_QUOTE) begin
                    if (quoting_next) begin
                        qwait_next = 1'b1;
                    end else begin
                        quoting_next = 1'b1;
                    end
                end else if ((s_tdata == csvt_pkg::CH_COMMA) && !quoting_next) begin
                    end_a        = 1'b1;
                    le_a         = 1'b0;
                    of_a         = ovf_reg;
                    content_next = 1'b0;
                    held_next    = '0;
                    ovf_next     = 1'b0;
                end else begin
                    content_en = 1'b1;
                end
            end

            if (content_en) begin
                if (csvt_pkg::is_space(s_tdata)) begin
                    // Leading whitespace is dropped; inner whitespace is held.
                    if (content_reg) begin
                        if (held_reg < CW'(csvt_pkg::HOLD_DEPTH)) begin
                            ws_we     = 1'b1;
                            held_next = held_reg + CW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end else begin
                    do_flush     = (held_reg != '0);
                    held_next    = '0;
                    has_byte     = 1'b1;
                    content_next = 1'b1;
                end
            end
        end

        if (s_tlast) begin
            end_b           = line_bytes_next;
            of_b            = ovf_next;
            quoting_next    = 1'b0;
            qwait_next      = 1'b0;
            line_bytes_next = 1'b0;
            content_next    = 1'b0;
            held_next       = '0;
            ovf_next        = 1'b0;
        end
    end

    // First result of a byte that releases no held whitespace.
    always_comb begin
        fast_valid = !do_flush && (has_byte || end_a || end_b);
        fast_kind  = csvt_pkg::KIND_END;
        fast_ch    = 8'h00;
        fast_le    = 1'b1;
        fast_te    = 1'b1;
        fast_of    = of_b;
        if (has_byte) begin
            fast_kind = csvt_pkg::KIND_BYTE;
            fast_ch   = s_tdata;
            fast_le   = 1'b0;
            fast_te   = 1'b0;
            fast_of   = 1'b0;
        end else if (end_a) begin
            fast_le = le_a;
            fast_te = s_tlast && !end_b;
            fast_of = of_a;
        end
    end

    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.has_flush  = do_flush;
    assign stat.rest_endb  = end_b && (has_byte || end_a);
    assign stat.flush_done = (flush_idx_reg == (flush_len_reg - CW'(1)));
    assign stat.plan_endb  = plan_endb_reg;

    always_comb begin
        flush_idx_next = flush_idx_reg;
        if (cmd.sel == csvt_pkg::SEL_FAST) begin
            flush_idx_next = '0;
        end else if ((cmd.sel == csvt_pkg::SEL_FLUSH) && !stat.flush_done) begin
            flush_idx_next = flush_idx_reg + CW'(1);
        end
    end

    csvt_ram #(
        .WIDTH(8),
        .DEPTH(csvt_pkg::HOLD_DEPTH)
    ) u_hold (
        .aclk (aclk),
        .we   (cmd.accept && ws_we),
        .waddr(held_reg[AW-1:0]),
        .wdata(s_tdata),
        .raddr(flush_idx_next[AW-1:0]),
        .rdata(rd_data)
    );

    assign load = ((cmd.sel == csvt_pkg::SEL_FAST) && fast_valid) ||
                  (cmd.sel == csvt_pkg::SEL_FLUSH) ||
                  (cmd.sel == csvt_pkg::SEL_BYTE) ||
                  (cmd.sel == csvt_pkg::SEL_ENDB);

    assign out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quoting_reg    <= 1'b0;
            qwait_reg      <= 1'b0;
            line_bytes_reg <= 1'b0;
            content_reg    <= 1'b0;
            held_reg       <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            flush_idx_reg  <= '0;
        end else begin
            if (cmd.accept) begin
                quoting_reg    <= quoting_next;
                qwait_reg      <= qwait_next;
                line_bytes_reg <= line_bytes_next;
                content_reg    <= content_next;
                held_reg       <= held_next;
                ovf_reg        <= ovf_next;
            end
            out_valid_reg <= out_valid_next;
            flush_idx_reg <= flush_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg      <= s_tdata;
            plan_endb_reg <= end_b;
            plan_ofb_reg  <= of_b;
            flush_len_reg <= held_reg;
        end
        case (cmd.sel)
            csvt_pkg::SEL_FAST: begin
                out_kind_reg <= fast_kind;
                out_ch_reg   <= fast_ch;
                out_le_reg   <= fast_le;
                out_te_reg   <= fast_te;
                out_of_reg   <= fast_of;
            end
            csvt_pkg::SEL_FLUSH: begin
                out_kind_reg <= csvt_pkg::KIND_BYTE;
                out_ch_reg   <= rd_data;
                out_le_reg   <= 1'b0;
                out_te_reg   <= 1'b0;
                out_of_reg   <= 1'b0;
            end
            csvt_pkg::SEL_BYTE: begin
                out_kind_reg <= csvt_pkg::KIND_BYTE;
                out_ch_reg   <= byte_reg;
                out_le_reg   <= 1'b0;
                out_te_reg   <= 1'b0;
                out_of_reg   <= 1'b0;
            end
            csvt_pkg::SEL_ENDB: begin
                out_kind_reg <= csvt_pkg::KIND_END;
                out_ch_reg   <= 8'h00;
                out_le_reg   <= 1'b1;
                out_te_reg   <= 1'b1;
                out_of_reg   <= plan_ofb_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_ch_reg;
    assign m_tuser  = {out_of_reg, out_le_reg, out_kind_reg};
    assign m_tlast  = out_te_reg;

endmodule

>>> hw/rtl/csv_line_field_tokenizer.sv
// Top level of the streaming CSV line field tokenizer.
`timescale 1ns / 1ps

// The tokenizer takes a text one byte per slave transaction, with s_tlast on
// the final byte, and emits field bytes and field-end markers as master
// transactions. CR, LF and CRLF end a line, empty lines give nothing, commas
// outside quotes split fields, and a doubled quote inside quotes gives one
// literal quote. Leading and trailing whitespace of each field is removed;
// whitespace after content is held in a HOLD_DEPTH-entry buffer and released
// ahead of the next content byte, and whitespace that finds the buffer full
// is dropped and reported with the field end. Ordinary text, whose bytes each
// yield at most one result, streams at one byte per clock while the output is
// not stalled. A byte that yields more results stalls the input while they
// pass through the single output register; a byte that releases held
// whitespace is first taken with no result while the hold buffer's single
// read port fetches, then the held bytes, the content byte and, for the final
// byte, its field end follow. There is no clearing pass after reset.
module csv_line_field_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // text_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic [2:0] m_tuser,   // [0] kind, [1] line_end, [2] ws_overflow
    output logic       m_tlast    // text_end
);

    csvt_pkg::cmd_t  cmd;
    csvt_pkg::stat_t stat;

    // The controller decides when a transaction is taken and which pending
    // result goes to the output register next.
    csvt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the quote and line state, the whitespace buffer and
    // the output register.
    csvt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

>>> hw/rtl/csvt_checker.sv
// Port-level checker for the CSV line field tokenizer, with its bind.
`timescale 1ns / 1ps

module csvt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result transaction holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // Field bytes never carry end-of-field flags.
    a_byte_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> !m_tuser[1] && !m_tuser[2] && !m_tlast)
        else $error("field byte carries end flags");

    // Field ends carry a zero character.
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'h00)
        else $error("field end carries a character");

    // The last result of a text always closes a line.
    a_text_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0] && m_tuser[1])
        else $error("text end without line end");

    // No result is offered right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind csv_line_field_tokenizer csvt_checker u_csvt_checker (.*);
